### sv/spbc_pkg.sv
// Shared types, constants and the microcode program of the blower flow controller.
package spbc_pkg;

    // Field and state widths.
    localparam int FLOW_W  = 13;
    localparam int PWM_W   = 7;
    localparam int INTEG_W = 14;
    localparam int DUTY_W  = 19;

    // Event kinds carried by an input beat.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_FLOW_TARGET = 2'd0;
    localparam logic [1:0] REG_FLOW_LOW    = 2'd1;
    localparam logic [1:0] REG_FLOW_HIGH   = 2'd2;

    // Configuration reset values.
    localparam logic [FLOW_W-1:0] FLOW_TARGET_RST = 13'd4096;
    localparam logic [FLOW_W-1:0] FLOW_LOW_RST    = 13'd3277;
    localparam logic [FLOW_W-1:0] FLOW_HIGH_RST   = 13'd4915;

    // Arithmetic constants.
    localparam logic [11:0]        SQRT_SCALE = 12'd2275;
    localparam logic [15:0]        RECIP_10   = 16'd52429;
    localparam logic [15:0]        RECIP_5    = 16'd52429;
    localparam logic [INTEG_W-1:0] INTEG_MAX  = 14'd13107;
    localparam logic [DUTY_W-1:0]  DUTY_BASE  = 19'd114688;
    localparam logic [DUTY_W-1:0]  DUTY_MIN   = 19'd65536;
    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 19'd294912;

    // Micro-operations executed by the datapath.
    typedef logic [3:0] uop_t;
    localparam uop_t OP_NOP      = 4'd0;
    localparam uop_t OP_SQ_LOAD  = 4'd1;
    localparam uop_t OP_SQ_STEP  = 4'd2;
    localparam uop_t OP_FLOW_SET = 4'd3;
    localparam uop_t OP_ERR      = 4'd4;
    localparam uop_t OP_MAG      = 4'd5;
    localparam uop_t OP_INTEG    = 4'd6;
    localparam uop_t OP_DUTY     = 4'd7;
    localparam uop_t OP_SCALE    = 4'd8;
    localparam uop_t OP_DIV5     = 4'd9;
    localparam uop_t OP_START    = 4'd10;
    localparam uop_t OP_STOP     = 4'd11;
    localparam uop_t OP_OUT      = 4'd12;

    // Jump conditions.
    typedef logic [2:0] ucond_t;
    localparam ucond_t COND_NEVER     = 3'd0;
    localparam ucond_t COND_ALWAYS    = 3'd1;
    localparam ucond_t COND_START     = 3'd2;
    localparam ucond_t COND_STOP      = 3'd3;
    localparam ucond_t COND_STOPPED   = 3'd4;
    localparam ucond_t COND_NO_SAMPLE = 3'd5;
    localparam ucond_t COND_NOT_TICK  = 3'd6;
    localparam ucond_t COND_SQ_MORE   = 3'd7;

    // Program addresses.
    typedef logic [3:0] upc_t;
    localparam upc_t ADDR_SQ_STEP = 4'd5;
    localparam upc_t ADDR_PI      = 4'd7;
    localparam upc_t ADDR_START   = 4'd13;
    localparam upc_t ADDR_STOP    = 4'd14;
    localparam upc_t ADDR_OUT     = 4'd15;

    // One control word of the program.
    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        logic [1:0] kind;
        logic       running;
        logic       sample_ok;
        logic       sq_more;
    } dp_status_t;

    // Control from the sequencer to the datapath and output stage.
    typedef struct packed {
        uop_t op;
        logic done;
    } dp_ctrl_t;

    // Microcode program, one word per step.
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        unique case (addr)
            4'd0:    w = '{op: OP_NOP,      cond: COND_START,     target: ADDR_START};
            4'd1:    w = '{op: OP_NOP,      cond: COND_STOP,      target: ADDR_STOP};
            4'd2:    w = '{op: OP_NOP,      cond: COND_STOPPED,   target: ADDR_OUT};
            4'd3:    w = '{op: OP_NOP,      cond: COND_NO_SAMPLE, target: ADDR_PI};
            4'd4:    w = '{op: OP_SQ_LOAD,  cond: COND_NEVER,     target: ADDR_OUT};
            4'd5:    w = '{op: OP_SQ_STEP,  cond: COND_SQ_MORE,   target: ADDR_SQ_STEP};
            4'd6:    w = '{op: OP_FLOW_SET, cond: COND_NEVER,     target: ADDR_OUT};
            4'd7:    w = '{op: OP_ERR,      cond: COND_NOT_TICK,  target: ADDR_OUT};
            4'd8:    w = '{op: OP_MAG,      cond: COND_NEVER,     target: ADDR_OUT};
            4'd9:    w = '{op: OP_INTEG,    cond: COND_NEVER,     target: ADDR_OUT};
            4'd10:   w = '{op: OP_DUTY,     cond: COND_NEVER,     target: ADDR_OUT};
            4'd11:   w = '{op: OP_SCALE,    cond: COND_NEVER,     target: ADDR_OUT};
            4'd12:   w = '{op: OP_DIV5,     cond: COND_ALWAYS,    target: ADDR_OUT};
            4'd13:   w = '{op: OP_START,    cond: COND_ALWAYS,    target: ADDR_OUT};
            4'd14:   w = '{op: OP_STOP,     cond: COND_NEVER,     target: ADDR_OUT};
            4'd15:   w = '{op: OP_OUT,      cond: COND_NEVER,     target: ADDR_OUT};
            default: w = '{op: OP_NOP,      cond: COND_NEVER,     target: ADDR_OUT};
        endcase
        return w;
    endfunction

endpackage

### sv/sqrt_flow_pi_blower_control_unit.sv
// Top level of the blower flow controller: handshakes, configuration and output register.

// Each input beat carries an event (control tick, start, stop or measure) and a
// differential-pressure sample, and yields exactly one output beat with the flow
// estimate, PWM compare count, window flag and run state. A microcoded sequencer
// runs one item at a time: a running item with a good sample first takes the
// square root loop, one digit per cycle, and a running tick then takes the PI
// step. in_stall is high while an item is in work; a finished beat waits in
// the output register while the next item is accepted. Configuration writes are
// always taken (cfg_ready is tied high) and index 3 is ignored.
module sqrt_flow_pi_blower_control_unit
    import spbc_pkg::*;
#(
    parameter int PWM_STEPS = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [15:0] raw_pressure,
    input  logic               sample_valid,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FLOW_W-1:0]  flow_now,
    output logic [PWM_W-1:0]   pwm_compare,
    output logic               flow_in_window,
    output logic               is_running,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [FLOW_W-1:0]  cfg_data
);

    logic               in_fire;
    logic               busy;
    logic               out_blocked;
    dp_status_t         status;
    dp_ctrl_t           ctrl;
    logic [FLOW_W-1:0]  flow_est;
    logic [PWM_W-1:0]   duty_count;
    logic               running;
    logic [FLOW_W-1:0]  flow_shown;

    logic [FLOW_W-1:0]  target_reg, target_next;
    logic [FLOW_W-1:0]  low_reg, low_next;
    logic [FLOW_W-1:0]  high_reg, high_next;
    logic               out_valid_reg, out_valid_next;
    logic [FLOW_W-1:0]  flow_out_reg, flow_out_next;
    logic [PWM_W-1:0]   pwm_out_reg, pwm_out_next;
    logic               win_out_reg, win_out_next;
    logic               run_out_reg, run_out_next;

    assign in_fire     = in_valid && !in_stall;
    assign in_stall    = busy;
    assign cfg_ready   = 1'b1;
    assign out_blocked = out_valid_reg && out_stall;

    spbc_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_fire),
        .out_blocked (out_blocked),
        .status      (status),
        .ctrl        (ctrl),
        .busy        (busy)
    );

    spbc_datapath #(
        .PWM_STEPS (PWM_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .load         (in_fire),
        .kind         (kind),
        .raw_pressure (raw_pressure),
        .sample_valid (sample_valid),
        .flow_target  (target_reg),
        .status       (status),
        .flow_est     (flow_est),
        .duty_count   (duty_count),
        .running      (running)
    );

    // Configuration register writes.
    always_comb
    begin
        target_next = target_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FLOW_TARGET: target_next = cfg_data;
                REG_FLOW_LOW:    low_next    = cfg_data;
                REG_FLOW_HIGH:   high_next   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Output register: loaded by the last program step, freed when the beat is taken.
    assign flow_shown = running ? flow_est : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        flow_out_next  = flow_out_reg;
        pwm_out_next   = pwm_out_reg;
        win_out_next   = win_out_reg;
        run_out_next   = run_out_reg;
        if (ctrl.done)
        begin
            out_valid_next = 1'b1;
            flow_out_next  = flow_shown;
            pwm_out_next   = running ? duty_count : '0;
            win_out_next   = (flow_shown >= low_reg) && (flow_shown <= high_reg);
            run_out_next   = running;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= FLOW_TARGET_RST;
            low_reg       <= FLOW_LOW_RST;
            high_reg      <= FLOW_HIGH_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_out_reg <= flow_out_next;
        pwm_out_reg  <= pwm_out_next;
        win_out_reg  <= win_out_next;
        run_out_reg  <= run_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign flow_now       = flow_out_reg;
    assign pwm_compare    = pwm_out_reg;
    assign flow_in_window = win_out_reg;
    assign is_running     = run_out_reg;

`ifndef SYNTHESIS
    // An accepted item keeps the input side stalled in the following cycle.
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // A stopped blower reports neither flow nor drive.
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_running) |-> (flow_now == '0 && pwm_compare == '0))
        else $error("stopped beat shows nonzero flow or compare");

    // A running blower always has a nonzero drive.
    a_running_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_running) |-> (pwm_compare != '0))
        else $error("running beat shows zero compare");
`endif

endmodule

### sv/spbc_sequencer.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
module spbc_sequencer
    import spbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       out_blocked,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl,
    output logic       busy
);

    logic   busy_reg;
    logic   busy_next;
    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t word;
    logic   jump;
    logic   hold;

    // Fetch the current control word.
    assign word = ucode_rom(pc_reg);

    // Evaluate the jump condition of the current word.
    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_START:     jump = (status.kind == KIND_START);
            COND_STOP:      jump = (status.kind == KIND_STOP);
            COND_STOPPED:   jump = !status.running;
            COND_NO_SAMPLE: jump = !status.sample_ok;
            COND_NOT_TICK:  jump = (status.kind != KIND_TICK);
            COND_SQ_MORE:   jump = status.sq_more;
            default:        jump = 1'b0;
        endcase
    end

    // The last step waits while the output register still holds an untaken beat.
    assign hold      = (word.op == OP_OUT) && out_blocked;
    assign ctrl.op   = busy_reg ? word.op : OP_NOP;
    assign ctrl.done = busy_reg && (word.op == OP_OUT) && !out_blocked;
    assign busy      = busy_reg;

    // Step counter update.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (busy_reg)
        begin
            if (ctrl.done)
            begin
                busy_next = 1'b0;
            end
            else if (!hold)
            begin
                pc_next = jump ? word.target : upc_t'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

### sv/spbc_datapath.sv
// Datapath: square root, PI arithmetic and controller state, driven by micro-operations.
module spbc_datapath
    import spbc_pkg::*;
#(
    parameter int PWM_STEPS = 100
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_ctrl_t          ctrl,
    input  logic              load,
    input  logic [1:0]        kind,
    input  logic signed [15:0] raw_pressure,
    input  logic              sample_valid,
    input  logic [FLOW_W-1:0] flow_target,
    output dp_status_t        status,
    output logic [FLOW_W-1:0] flow_est,
    output logic [PWM_W-1:0]  duty_count,
    output logic              running
);

    localparam int PS_W  = $clog2(PWM_STEPS + 1);
    localparam int SP_W  = DUTY_W + PS_W;
    localparam int Q_W   = SP_W - 16;
    localparam int D5_W  = Q_W + 16;
    localparam int START_RAW = PWM_STEPS * 2 / 5;
    localparam int START_SAT = (START_RAW > 127) ? 127 : START_RAW;
    localparam logic [PS_W-1:0]  PS_CONST  = PS_W'(PWM_STEPS);
    localparam logic [PWM_W-1:0] START_CNT = PWM_W'(START_SAT);

    // Architectural state.
    logic                running_reg, running_next;
    logic [FLOW_W-1:0]   flow_reg, flow_next;
    logic [INTEG_W-1:0]  integ_reg, integ_next;
    logic [PWM_W-1:0]    duty_reg, duty_next;

    // Working registers.
    logic [1:0]          kind_reg, kind_next;
    logic signed [15:0]  raw_reg, raw_next;
    logic                ok_reg, ok_next;
    logic [27:0]         x_reg, x_next;
    logic [15:0]         rem_reg, rem_next;
    logic [13:0]         root_reg, root_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic signed [13:0]  err_reg, err_next;
    logic [12:0]         mag_reg, mag_next;
    logic [DUTY_W-1:0]   d_reg, d_next;
    logic [Q_W-1:0]      q_reg, q_next;

    // Combinational helpers.
    logic [14:0]         r_clamp;
    logic [26:0]         sq_prod;
    logic [17:0]         rem_sh;
    logic [17:0]         trial;
    logic                sq_ge;
    logic [14:0]         root_inc;
    logic [12:0]         abs_err;
    logic [15:0]         mag_arg;
    logic [31:0]         mag_prod;
    logic signed [15:0]  delta;
    logic signed [15:0]  integ_sum;
    logic signed [19:0]  e20;
    logic signed [19:0]  dsum;
    logic [SP_W-1:0]     scale_prod;
    logic [D5_W-1:0]     div5_prod;
    logic [D5_W-1:0]     div5_q;

    assign status.kind      = kind_reg;
    assign status.running   = running_reg;
    assign status.sample_ok = ok_reg;
    assign status.sq_more   = (cnt_reg != 4'd0);
    assign flow_est   = flow_reg;
    assign duty_count = duty_reg;
    assign running    = running_reg;

    // Arithmetic shared by the micro-operations.
    always_comb
    begin
        // Negative samples count as zero before scaling.
        r_clamp = raw_reg[15] ? 15'd0 : raw_reg[14:0];
        sq_prod = 27'(r_clamp) * 27'(SQRT_SCALE);

        // One digit of the restoring square root.
        rem_sh   = {rem_reg, x_reg[27:26]};
        trial    = {2'b00, root_reg, 2'b01};
        sq_ge    = (rem_sh >= trial);
        root_inc = {1'b0, root_reg} + 15'd1;

        // Integrator increment: round(|4*err| / 10) with the sign of err.
        abs_err  = err_reg[13] ? 13'(-err_reg) : 13'(err_reg);
        mag_arg  = {1'b0, abs_err, 2'b00} + 16'd5;
        mag_prod = 32'(mag_arg) * 32'(RECIP_10);
        delta    = err_reg[13] ? -$signed({3'b000, mag_reg}) : $signed({3'b000, mag_reg});
        integ_sum = $signed({2'b00, integ_reg}) + delta;

        // Duty in tenths of Q15: base + 12*err + 3*integrator.
        e20  = {{6{err_reg[13]}}, err_reg};
        dsum = $signed({1'b0, DUTY_BASE}) + (e20 <<< 3) + (e20 <<< 2)
             + $signed({6'd0, integ_reg}) + $signed({5'd0, integ_reg, 1'b0});

        // Compare count: d * PWM_STEPS / 65536, then / 5.
        scale_prod = SP_W'(d_reg) * SP_W'(PS_CONST);
        div5_prod  = D5_W'(q_reg) * D5_W'(RECIP_5);
        div5_q     = div5_prod >> 18;
    end

    // Micro-operation decode.
    always_comb
    begin
        running_next = running_reg;
        flow_next    = flow_reg;
        integ_next   = integ_reg;
        duty_next    = duty_reg;
        kind_next    = kind_reg;
        raw_next     = raw_reg;
        ok_next      = ok_reg;
        x_next       = x_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        mag_next     = mag_reg;
        d_next       = d_reg;
        q_next       = q_reg;

        if (load)
        begin
            kind_next = kind;
            raw_next  = raw_pressure;
            ok_next   = sample_valid;
        end

        unique case (ctrl.op)
            OP_SQ_LOAD:
            begin
                x_next    = {1'b0, sq_prod};
                rem_next  = '0;
                root_next = '0;
                cnt_next  = 4'd13;
            end
            OP_SQ_STEP:
            begin
                x_next    = {x_reg[25:0], 2'b00};
                rem_next  = sq_ge ? 16'(rem_sh - trial) : 16'(rem_sh);
                root_next = {root_reg[12:0], sq_ge};
                cnt_next  = cnt_reg - 4'd1;
            end
            OP_FLOW_SET:
            begin
                flow_next = root_inc[13:1];
            end
            OP_ERR:
            begin
                err_next = $signed({1'b0, flow_target}) - $signed({1'b0, flow_reg});
            end
            OP_MAG:
            begin
                mag_next = mag_prod[31:19];
            end
            OP_INTEG:
            begin
                if (integ_sum < 16'sd0)
                begin
                    integ_next = '0;
                end
                else if (integ_sum > $signed({2'b00, INTEG_MAX}))
                begin
                    integ_next = INTEG_MAX;
                end
                else
                begin
                    integ_next = integ_sum[INTEG_W-1:0];
                end
            end
            OP_DUTY:
            begin
                if (dsum < $signed({1'b0, DUTY_MIN}))
                begin
                    d_next = DUTY_MIN;
                end
                else if (dsum > $signed({1'b0, DUTY_MAX}))
                begin
                    d_next = DUTY_MAX;
                end
                else
                begin
                    d_next = dsum[DUTY_W-1:0];
                end
            end
            OP_SCALE:
            begin
                q_next = scale_prod[SP_W-1:16];
            end
            OP_DIV5:
            begin
                if (div5_q > D5_W'(127))
                begin
                    duty_next = {PWM_W{1'b1}};
                end
                else
                begin
                    duty_next = div5_q[PWM_W-1:0];
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
                integ_next   = '0;
                duty_next    = START_CNT;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                duty_next    = '0;
                flow_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Controller state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            flow_reg    <= '0;
            integ_reg   <= '0;
            duty_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            flow_reg    <= flow_next;
            integ_reg   <= integ_next;
            duty_reg    <= duty_next;
        end
    end

    // Working registers, loaded before use.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        raw_reg  <= raw_next;
        ok_reg   <= ok_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        err_reg  <= err_next;
        mag_reg  <= mag_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
    end

endmodule

### dv/sqrt_flow_pi_blower_control_unit_tb.sv
// Self-checking testbench for the blower flow controller: stimulus, flow and duty prediction, checks.

// One output beat of the controller.
typedef struct packed {
    logic [12:0] flow;
    logic [6:0]  pwm;
    logic        in_window;
    logic        running;
} blower_beat_t;

// Tracks the controller state, predicts one output beat per input beat and checks them in order.
class blower_loop_tracker;
    int unsigned  steps;
    logic [12:0]  target_set;
    logic [12:0]  low_set;
    logic [12:0]  high_set;
    logic         run_flag;
    logic [12:0]  flow_est;
    int           integ_acc;
    logic [6:0]   duty_cnt;
    blower_beat_t awaited_beats[$];
    int           faults;

    function new(int unsigned pwm_steps);
        steps      = pwm_steps;
        target_set = spbc_pkg::FLOW_TARGET_RST;
        low_set    = spbc_pkg::FLOW_LOW_RST;
        high_set   = spbc_pkg::FLOW_HIGH_RST;
        run_flag   = 1'b0;
        flow_est   = '0;
        integ_acc  = 0;
        duty_cnt   = '0;
        faults     = 0;
    endfunction

    // Register writes; the unused index changes nothing.
    function void set_register(logic [1:0] idx, logic [12:0] data);
        if (idx == spbc_pkg::REG_FLOW_TARGET)
            target_set = data;
        else if (idx == spbc_pkg::REG_FLOW_LOW)
            low_set = data;
        else if (idx == spbc_pkg::REG_FLOW_HIGH)
            high_set = data;
    endfunction

    // Floor square root, one result bit per pass from the top.
    function int unsigned root_floor(int unsigned x);
        int unsigned res;
        longint unsigned cand;
        res = 0;
        for (int i = 15; i >= 0; i--)
        begin
            cand = res | (32'd1 << i);
            if (cand * cand <= x)
                res = cand;
        end
        return res;
    endfunction

    // Saturate a compare count into the 7-bit port range.
    function logic [6:0] clip_count(longint c);
        if (c < 0)
            return 7'd0;
        if (c > 127)
            return 7'd127;
        return c[6:0];
    endfunction

    // One PI step on the held flow estimate.
    function void pi_update();
        int     err;
        int     t4;
        int     mag;
        longint d;
        err = int'(target_set) - int'(flow_est);
        t4  = err * 4;
        mag = ((t4 < 0 ? -t4 : t4) + 5) / 10;
        integ_acc += (t4 < 0) ? -mag : mag;
        if (integ_acc > 13107)
            integ_acc = 13107;
        if (integ_acc < 0)
            integ_acc = 0;
        d = 64'sd114688 + longint'(err) * 12 + longint'(integ_acc) * 3;
        if (d > 294912)
            d = 294912;
        if (d < 65536)
            d = 65536;
        duty_cnt = clip_count(d * steps / 327680);
    endfunction

    // Note an accepted input beat and queue the beat it must produce.
    function void log_event(logic [1:0] k, logic signed [15:0] p, logic s);
        blower_beat_t exp_beat;
        int unsigned  r;
        if (k == spbc_pkg::KIND_START)
        begin
            run_flag  = 1'b1;
            integ_acc = 0;
            duty_cnt  = clip_count(longint'(steps) * 2 / 5);
        end
        else if (k == spbc_pkg::KIND_STOP)
        begin
            run_flag = 1'b0;
            duty_cnt = '0;
            flow_est = '0;
        end
        else if (run_flag)
        begin
            if (s)
            begin
                r = (p < 0) ? 0 : int'(p);
                flow_est = 13'((root_floor(r * 2275) + 1) >> 1);
            end
            if (k == spbc_pkg::KIND_TICK)
                pi_update();
        end
        exp_beat.flow      = run_flag ? flow_est : 13'd0;
        exp_beat.pwm       = run_flag ? duty_cnt : 7'd0;
        exp_beat.in_window = (exp_beat.flow >= low_set) && (exp_beat.flow <= high_set);
        exp_beat.running   = run_flag;
        awaited_beats.push_back(exp_beat);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            faults++;
        end
    endfunction

    // Check an accepted output beat against the oldest prediction.
    function void verify_beat(blower_beat_t got);
        blower_beat_t exp_beat;
        if (awaited_beats.size() == 0)
        begin
            $display("%0t: output beat with none expected, actual flow %0d pwm %0d", $time,
                     got.flow, got.pwm);
            faults++;
            return;
        end
        exp_beat = awaited_beats.pop_front();
        compare_field("flow_now", exp_beat.flow, got.flow);
        compare_field("pwm_compare", exp_beat.pwm, got.pwm);
        compare_field("flow_in_window", exp_beat.in_window, got.in_window);
        compare_field("is_running", exp_beat.running, got.running);
    endfunction

    function int outstanding();
        return awaited_beats.size();
    endfunction
endclass

module sqrt_flow_pi_blower_control_unit_tb;
    import spbc_pkg::*;

    localparam int         STEPS        = 100;
    localparam logic [1:0] KIND_MEASURE = 2'd3;
    localparam logic [1:0] REG_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT  = 3000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 40;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [1:0]         kind           = KIND_TICK;
    logic signed [15:0] raw_pressure   = '0;
    logic               sample_valid   = 1'b0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [FLOW_W-1:0]  flow_now;
    logic [PWM_W-1:0]   pwm_compare;
    logic               flow_in_window;
    logic               is_running;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index      = REG_FLOW_TARGET;
    logic [FLOW_W-1:0]  cfg_data       = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;

    blower_loop_tracker tracker = new(STEPS);

    sqrt_flow_pi_blower_control_unit #(
        .PWM_STEPS(STEPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .raw_pressure(raw_pressure),
        .sample_valid(sample_valid),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .flow_now(flow_now),
        .pwm_compare(pwm_compare),
        .flow_in_window(flow_in_window),
        .is_running(is_running),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Output check and a watchdog on cycles without any beat.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tracker.verify_beat('{flow: flow_now, pwm: pwm_compare,
                                  in_window: flow_in_window, running: is_running});
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one input beat after a random idle gap and wait for it to be taken.
    task automatic send_item(input logic [1:0] k, input logic signed [15:0] p, input logic s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        raw_pressure <= p;
        sample_valid <= s;
        do
            @(posedge clk);
        while (in_stall);
        tracker.log_event(k, p, s);
    endtask

    // Stop offering and wait until every expected beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_register(idx, data);
    endtask

    task automatic write_settings(input logic [12:0] target, input logic [12:0] low,
                                  input logic [12:0] high);
        write_reg(REG_FLOW_TARGET, target);
        write_reg(REG_FLOW_LOW, low);
        write_reg(REG_FLOW_HIGH, high);
        write_reg(REG_UNUSED, 13'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Random beats: mostly running sequences with real samples, some noise.
    task automatic run_random(input int count);
        logic [1:0]         k;
        logic signed [15:0] p;
        logic               s;
        int                 roll;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 6)
            begin
                k = 2'($urandom_range(3));
                p = 16'($urandom);
                s = 1'($urandom_range(1));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                    k = KIND_START;
                else if (roll < 9)
                    k = KIND_STOP;
                else if (roll < 64)
                    k = KIND_TICK;
                else
                    k = KIND_MEASURE;
                roll = $urandom_range(99);
                if (roll < 50)
                    p = 16'($urandom_range(0, 32767));
                else if (roll < 65)
                    p = 16'($urandom_range(0, 200));
                else if (roll < 75)
                    p = 16'($urandom);
                else
                    p = 16'($urandom_range(25000, 32767));
                s = ($urandom_range(99) < 90);
            end
            send_item(k, p, s);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings, no idling.
        send_item(KIND_TICK, 16'sd100, 1'b1);
        send_item(KIND_MEASURE, 16'sd32767, 1'b1);
        send_item(KIND_STOP, -16'sd5, 1'b0);
        send_item(KIND_START, 16'sd0, 1'b1);
        send_item(KIND_MEASURE, 16'sd0, 1'b1);
        send_item(KIND_MEASURE, 16'sd32767, 1'b1);
        send_item(KIND_TICK, 16'sd32767, 1'b1);
        send_item(KIND_TICK, -16'sd32768, 1'b1);
        send_item(KIND_TICK, -16'sd1, 1'b1);
        send_item(KIND_MEASURE, 16'sd1000, 1'b0);
        send_item(KIND_TICK, 16'sd5000, 1'b0);
        send_item(KIND_TICK, 16'sd1, 1'b1);
        // Zero flow drives the integrator into its upper clamp.
        repeat (9) send_item(KIND_TICK, 16'sd0, 1'b1);
        // Restart clears the integrator.
        send_item(KIND_STOP, 16'sd29498, 1'b1);
        send_item(KIND_START, 16'sd29498, 1'b1);
        send_item(KIND_TICK, 16'sd29498, 1'b1);
        drain();

        // Widest window and highest setpoint, no idling.
        write_settings(13'd8191, 13'd0, 13'd8191);
        run_random(140);
        drain();

        // Zero setpoint and inverted window, sender mostly idle.
        write_settings(13'd0, 13'd8191, 13'd0);
        send_idle_pct = 80;
        run_random(140);
        drain();

        // Random settings, receiver mostly stalling.
        write_settings(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                       13'($urandom_range(0, 8191)));
        send_idle_pct = 0;
        recv_stall_pct = 80;
        run_random(140);
        drain();

        // Default settings with light idling on both sides, then a long receiver hold-off.
        write_settings(FLOW_TARGET_RST, FLOW_LOW_RST, FLOW_HIGH_RST);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        run_random(60);
        send_idle_pct = 0;
        hold_req = hold_req + 1;
        send_item(KIND_START, 16'sd20000, 1'b1);
        run_random(12);
        send_idle_pct = 19;
        run_random(70);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.faults == 0 && tracker.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### sim.f
sv/spbc_pkg.sv
sv/spbc_sequencer.sv
sv/spbc_datapath.sv
sv/sqrt_flow_pi_blower_control_unit.sv
dv/sqrt_flow_pi_blower_control_unit_tb.sv
